// ===== rtl/cucc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cucc_pkg: chunked upload CRC checker shared definitions
// Command and response codes, item and response records, CRC-32 byte update.
// ---------------------------------------------------------------------------
package cucc_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_END   = 2'd2
  } cmd_t;

  localparam logic [1:0] RESP_START = 2'd0;
  localparam logic [1:0] RESP_CHUNK = 2'd1;
  localparam logic [1:0] RESP_END   = 2'd2;

  localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY_RESET = 32'hEDB8_8320;
  localparam logic [31:0] END_ACK_VALUE  = 32'd1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] total_size;
    logic [31:0] expected_crc;
    logic [31:0] chunk_offset;
    logic        chunk_first;
    logic        chunk_last;
    logic        byte_valid;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  resp_kind;
    logic [31:0] resp_value;
    logic        complete;
    logic        crc_ok;
  } resp_t;

  // Reflected CRC-32, one byte: eight bit steps unrolled.
  function automatic logic [31:0] crc_byte_update(input logic [31:0] crc,
                                                  input logic [7:0]  data,
                                                  input logic [31:0] poly);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = {1'b0, c[31:1]} ^ (c[0] ? poly : 32'd0);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cucc_in_stage.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cucc_in_stage: input register
// Captures one item per transfer and holds it until the core consumes it.
// ---------------------------------------------------------------------------
module cucc_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire cucc_pkg::item_t in_item,
  input  wire logic           adv,
  output logic                s1_valid,
  output cucc_pkg::item_t     s1_item
);
  import cucc_pkg::*;

  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r;

  assign in_ready     = !s1_valid_r || adv;
  assign s1_valid_nxt = in_ready ? in_valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;
endmodule
`default_nettype wire

// ===== rtl/cucc_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cucc_core: upload state and per-item update
// Holds size, count, CRC and chunk acceptance; forms the response of an item.
// ---------------------------------------------------------------------------
module cucc_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [31:0]     cfg_wdata,
  input  wire logic            fire,
  input  wire cucc_pkg::item_t item,
  output logic                 res_valid,
  output cucc_pkg::resp_t      res
);
  import cucc_pkg::*;

  logic [31:0] poly_r, poly_nxt;
  logic [31:0] bytes_r, bytes_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] target_r, target_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        acc_r, acc_nxt;

  logic        acc_eff;
  logic        upd;
  logic [31:0] crc_data;
  logic [31:0] bytes_data;
  logic        comp;

  assign poly_nxt = cfg_we ? cfg_wdata : poly_r;

  always_comb begin
    bytes_nxt  = bytes_r;
    size_nxt   = size_r;
    target_nxt = target_r;
    crc_nxt    = crc_r;
    acc_nxt    = acc_r;
    res_valid  = 1'b0;
    res        = '0;

    acc_eff    = item.chunk_first ? (item.chunk_offset == bytes_r) : acc_r;
    upd        = acc_eff && item.byte_valid;
    crc_data   = upd ? crc_byte_update(crc_r, item.data_byte, poly_r) : crc_r;
    bytes_data = upd ? bytes_r + 32'd1 : bytes_r;
    comp       = (bytes_data >= size_r) && (item.chunk_offset == size_r);

    case (item.cmd)
      CMD_START: begin
        size_nxt       = item.total_size;
        target_nxt     = item.expected_crc;
        bytes_nxt      = '0;
        crc_nxt        = ALL_ONES;
        acc_nxt        = 1'b0;
        res_valid      = 1'b1;
        res.resp_kind  = RESP_START;
        res.resp_value = item.total_size;
      end
      CMD_DATA: begin
        crc_nxt   = crc_data;
        bytes_nxt = bytes_data;
        acc_nxt   = item.chunk_last ? 1'b0 : acc_eff;
        if (item.chunk_last) begin
          res_valid      = 1'b1;
          res.resp_kind  = RESP_CHUNK;
          res.resp_value = item.chunk_offset;
          res.complete   = comp;
          res.crc_ok     = comp && ((crc_data ^ ALL_ONES) == target_r);
        end
      end
      CMD_END: begin
        // Acknowledge only once the count has reached the size.
        if (bytes_r >= size_r) begin
          target_nxt     = '0;
          size_nxt       = '0;
          bytes_nxt      = '0;
          acc_nxt        = 1'b0;
          res_valid      = 1'b1;
          res.resp_kind  = RESP_END;
          res.resp_value = END_ACK_VALUE;
        end
      end
      default: begin
        // Unknown command: drop.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r   <= CRC_POLY_RESET;
      bytes_r  <= '0;
      size_r   <= '0;
      target_r <= '0;
      crc_r    <= ALL_ONES;
      acc_r    <= 1'b0;
    end else begin
      poly_r <= poly_nxt;
      if (fire) begin
        bytes_r  <= bytes_nxt;
        size_r   <= size_nxt;
        target_r <= target_nxt;
        crc_r    <= crc_nxt;
        acc_r    <= acc_nxt;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/cucc_out_stage.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cucc_out_stage: result register
// Holds one response until the receiver takes it.
// ---------------------------------------------------------------------------
module cucc_out_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire logic            res_valid,
  input  wire cucc_pkg::resp_t res,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output logic                 adv,
  output cucc_pkg::resp_t      out_resp
);
  import cucc_pkg::*;

  logic  out_valid_r, out_valid_nxt;
  resp_t out_resp_r;

  assign adv           = !out_valid_r || out_ready;
  assign out_valid_nxt = adv ? (fire && res_valid) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_resp_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_resp  = out_resp_r;
endmodule
`default_nettype wire

// ===== rtl/chunked_upload_crc_checker_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// chunked_upload_crc_checker_top: chunked upload receiver with CRC-32 check
// Tracks the bytes of an in-order chunked upload and checks its CRC-32.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one command per transfer - start, data item or end.
//   Output channel (out_*): start acks, chunk acks on the last item of each
//   chunk, and end acks once the whole upload has arrived.
//   Config port (cfg_*): cfg_we writes the reflected CRC polynomial; write it
//   only while the block is idle.
// Path: an item taken from the input channel is held in the input register and
//   processed by the core from there; its response is captured in the output
//   register, which drives out_valid.
// Throughput: one item per cycle while the output register can take a response.
//   The CRC byte update (eight unrolled bit steps) and the count compare sit
//   between the input register and the upload state registers.
// Reset: rst_n (synchronous, active low) clears the count, size and target,
//   presets the running CRC to all ones and restores the standard polynomial.
// Stall: with out_ready low and a response waiting, the input register still
//   takes one item; after that in_ready drops until the response is taken.
// ---------------------------------------------------------------------------
module chunked_upload_crc_checker_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [31:0] in_total_size,
  input  wire logic [31:0] in_expected_crc,
  input  wire logic [31:0] in_chunk_offset,
  input  wire logic        in_chunk_first,
  input  wire logic        in_chunk_last,
  input  wire logic        in_byte_valid,
  input  wire logic [7:0]  in_data_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_resp_kind,
  output logic [31:0]      out_resp_value,
  output logic             out_complete,
  output logic             out_crc_ok
);
  import cucc_pkg::*;

  item_t in_item;
  item_t s1_item;
  logic  s1_valid;
  logic  adv;
  logic  fire;
  logic  res_valid;
  resp_t res;
  resp_t out_resp;

  // Gather the input fields into one record.
  assign in_item = '{cmd:          in_cmd,
                     total_size:   in_total_size,
                     expected_crc: in_expected_crc,
                     chunk_offset: in_chunk_offset,
                     chunk_first:  in_chunk_first,
                     chunk_last:   in_chunk_last,
                     byte_valid:   in_byte_valid,
                     data_byte:    in_data_byte};

  // Advance the held item whenever the output register can take a response.
  assign fire = s1_valid && adv;

  cucc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  cucc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  cucc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .adv       (adv),
    .out_resp  (out_resp)
  );

  assign out_resp_kind  = out_resp.resp_kind;
  assign out_resp_value = out_resp.resp_value;
  assign out_complete   = out_resp.complete;
  assign out_crc_ok     = out_resp.crc_ok;

`ifndef SYNTHESIS
  // A CRC match is only reported on a completed upload.
  a_crc_ok_needs_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_crc_ok |-> out_complete)
    else $error("crc_ok without complete");

  // Start and end acks never carry the chunk flags.
  a_flags_only_on_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_resp_kind != RESP_CHUNK) |-> !out_complete && !out_crc_ok)
    else $error("completion flags on a non-chunk ack");

  // End acks always carry the value one.
  a_end_ack_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_resp_kind == RESP_END) |-> out_resp_value == END_ACK_VALUE)
    else $error("end ack with wrong value");

  // An empty input register always takes a transfer.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid |-> in_ready)
    else $error("input stalled while empty");
`endif
endmodule
`default_nettype wire
